/* rtl/core/i2cm_pkg.sv */
package i2cm_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_DATA  = 2'd3;

    // queue between front and engine
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // bit index of the ack slot, after the eight data bits
    localparam logic [3:0] ACK_BIT = 4'd8;

    // msb of a byte, and the read flag of a device byte
    localparam logic [7:0] BYTE_MSB  = 8'h80;
    localparam logic [7:0] READ_FLAG = 8'h01;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       need_data;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        logic       success;
    } out_t;

    // classified command handed to the engine
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       is_read;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_in;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // bus sequencer states
    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_START   = 9'b000000010,
        ST_DEV_W   = 9'b000000100,
        ST_REG     = 9'b000001000,
        ST_WDATA   = 9'b000010000,
        ST_RESTART = 9'b000100000,
        ST_DEV_R   = 9'b001000000,
        ST_RDATA   = 9'b010000000,
        ST_STOP    = 9'b100000000
    } seq_state_t;

endpackage

/* rtl/core/i2cm_front.sv */
module i2cm_front (
    input  i2cm_pkg::in_t  in_word,
    output i2cm_pkg::cmd_t cmd
);

    // classify the operation and settle the read count
    always_comb begin
        cmd.is_read    = 1'b0;
        cmd.dev_addr   = in_word.dev_addr;
        cmd.reg_addr   = in_word.reg_addr;
        cmd.byte_count = in_word.byte_count;
        cmd.data_byte  = in_word.data_byte;
        cmd.sda_in     = in_word.sda_in;
        case (in_word.op)
            i2cm_pkg::OP_TICK: begin
                cmd.kind = i2cm_pkg::CMD_TICK;
            end
            i2cm_pkg::OP_WRITE: begin
                cmd.kind = i2cm_pkg::CMD_BEGIN;
            end
            i2cm_pkg::OP_READ: begin
                cmd.kind    = i2cm_pkg::CMD_BEGIN;
                cmd.is_read = 1'b1;
                // a read of zero bytes reads one
                if (in_word.byte_count == 8'd0) begin
                    cmd.byte_count = 8'd1;
                end
            end
            default: begin
                cmd.kind = i2cm_pkg::CMD_DATA;
            end
        endcase
    end

endmodule

/* rtl/core/i2cm_fifo.sv */
module i2cm_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  i2cm_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output i2cm_pkg::cmd_t      head_cmd,
    output i2cm_pkg::fifo_stat_t stat
);

    i2cm_pkg::cmd_t                    entry_reg [i2cm_pkg::FIFO_DEPTH];
    logic [i2cm_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [i2cm_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [i2cm_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                              do_push, do_pop;

    assign stat.full  = (count_reg == i2cm_pkg::FIFO_CNT_W'(i2cm_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == i2cm_pkg::FIFO_PTR_W'(i2cm_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == i2cm_pkg::FIFO_PTR_W'(i2cm_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/i2cm_engine.sv */
module i2cm_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  i2cm_pkg::cmd_t       cmd,
    input  i2cm_pkg::fifo_stat_t stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cm_pkg::out_t       m_data
);

    i2cm_pkg::seq_state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] regaddr_reg, regaddr_next;
    logic [7:0] pend_reg, pend_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       ack_reg, ack_next;
    logic       is_read_reg, is_read_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       m_valid_reg;
    i2cm_pkg::out_t out_reg, out_next;
    logic       transmit;
    logic       stall;
    logic [7:0] left_dec;
    logic [7:0] tx_mask;

    // take a command whenever the output slot is free or drains
    assign pop     = !stat.empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign transmit = (state_reg != i2cm_pkg::ST_RDATA);
    assign left_dec = left_reg - 8'd1;
    assign tx_mask  = i2cm_pkg::BYTE_MSB >> bit_reg[2:0];

    // one bus phase per tick
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        left_next       = left_reg;
        dev_next        = dev_reg;
        regaddr_next    = regaddr_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        ack_next        = ack_reg;
        is_read_next    = is_read_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        stall           = 1'b0;
        out_next        = '0;

        case (cmd.kind)
            i2cm_pkg::CMD_BEGIN: begin
                if (state_reg == i2cm_pkg::ST_IDLE) begin
                    dev_next        = cmd.dev_addr;
                    regaddr_next    = cmd.reg_addr;
                    left_next       = cmd.byte_count;
                    is_read_next    = cmd.is_read;
                    pend_valid_next = 1'b0;
                    ack_next        = 1'b1;
                    state_next      = i2cm_pkg::ST_START;
                    phase_next      = 2'd0;
                    bit_next        = 4'd0;
                    shift_next      = 8'd0;
                end
            end
            i2cm_pkg::CMD_DATA: begin
                pend_next       = cmd.data_byte;
                pend_valid_next = 1'b1;
            end
            default: begin
                case (state_reg)
                    i2cm_pkg::ST_IDLE: begin
                    end
                    i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
                        if (phase_reg == 2'd0) begin
                            sda_next   = 1'b1;
                            phase_next = 2'd1;
                        end else if (phase_reg == 2'd1) begin
                            scl_next   = 1'b1;
                            phase_next = 2'd2;
                        end else begin
                            sda_next   = 1'b0;
                            phase_next = 2'd0;
                            bit_next   = 4'd0;
                            if (state_reg == i2cm_pkg::ST_START) begin
                                state_next = i2cm_pkg::ST_DEV_W;
                                shift_next = dev_reg;
                            end else begin
                                state_next = i2cm_pkg::ST_DEV_R;
                                shift_next = dev_reg | i2cm_pkg::READ_FLAG;
                            end
                        end
                    end
                    i2cm_pkg::ST_STOP: begin
                        if (phase_reg == 2'd0) begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = 2'd1;
                        end else if (phase_reg == 2'd1) begin
                            scl_next   = 1'b1;
                            phase_next = 2'd2;
                        end else begin
                            sda_next         = 1'b1;
                            out_next.done_res = 1'b1;
                            out_next.success  = ack_reg;
                            state_next       = i2cm_pkg::ST_IDLE;
                            phase_next       = 2'd0;
                            bit_next         = 4'd0;
                            shift_next       = 8'd0;
                        end
                    end
                    i2cm_pkg::ST_DEV_W, i2cm_pkg::ST_REG, i2cm_pkg::ST_WDATA,
                    i2cm_pkg::ST_DEV_R, i2cm_pkg::ST_RDATA: begin
                        if (phase_reg == 2'd0) begin
                            // fetch the next write byte at the first bit
                            if (state_reg == i2cm_pkg::ST_WDATA && bit_reg == 4'd0) begin
                                if (pend_valid_reg) begin
                                    shift_next      = pend_reg;
                                    pend_valid_next = 1'b0;
                                end else begin
                                    stall = 1'b1;
                                end
                            end
                            scl_next = 1'b0;
                            if (!stall) begin
                                if (bit_reg < i2cm_pkg::ACK_BIT) begin
                                    sda_next = transmit ? |(shift_next & tx_mask) : 1'b1;
                                end else begin
                                    // ack slot: release, or ack/nack a read byte
                                    sda_next = transmit ? 1'b1 : (left_reg <= 8'd1);
                                end
                                phase_next = 2'd1;
                            end
                        end else if (phase_reg == 2'd1) begin
                            scl_next   = 1'b1;
                            phase_next = 2'd2;
                        end else if (bit_reg < i2cm_pkg::ACK_BIT) begin
                            if (!transmit) begin
                                shift_next = {shift_reg[6:0], cmd.sda_in};
                                if (bit_reg == 4'd7) begin
                                    out_next.read_valid = 1'b1;
                                    out_next.read_data  = {shift_reg[6:0], cmd.sda_in};
                                end
                            end
                            bit_next   = bit_reg + 4'd1;
                            phase_next = 2'd0;
                        end else begin
                            // ack sampled, pick the next step
                            phase_next = 2'd0;
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            if (transmit && cmd.sda_in) begin
                                ack_next   = 1'b0;
                                state_next = i2cm_pkg::ST_STOP;
                            end else begin
                                case (state_reg)
                                    i2cm_pkg::ST_DEV_W: begin
                                        state_next = i2cm_pkg::ST_REG;
                                        shift_next = regaddr_reg;
                                    end
                                    i2cm_pkg::ST_REG: begin
                                        if (is_read_reg) begin
                                            state_next = i2cm_pkg::ST_RESTART;
                                        end else if (left_reg == 8'd0) begin
                                            state_next = i2cm_pkg::ST_STOP;
                                        end else begin
                                            state_next = i2cm_pkg::ST_WDATA;
                                        end
                                    end
                                    i2cm_pkg::ST_DEV_R: begin
                                        state_next = i2cm_pkg::ST_RDATA;
                                    end
                                    default: begin
                                        left_next  = left_dec;
                                        state_next = (left_dec == 8'd0)
                                                   ? i2cm_pkg::ST_STOP : state_reg;
                                    end
                                endcase
                            end
                        end
                    end
                    default: begin
                        state_next = i2cm_pkg::ST_IDLE;
                        phase_next = 2'd0;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                endcase
            end
        endcase

        // status seen after this word
        out_next.scl_out   = scl_next;
        out_next.sda_out   = sda_next;
        out_next.busy_res  = (state_next != i2cm_pkg::ST_IDLE);
        out_next.need_data = (state_next == i2cm_pkg::ST_WDATA) && (bit_next == 4'd0)
                          && (phase_next == 2'd0) && !pend_valid_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= i2cm_pkg::ST_IDLE;
            phase_reg      <= 2'd0;
            bit_reg        <= 4'd0;
            shift_reg      <= 8'd0;
            left_reg       <= 8'd0;
            dev_reg        <= 8'd0;
            regaddr_reg    <= 8'd0;
            pend_reg       <= 8'd0;
            pend_valid_reg <= 1'b0;
            ack_reg        <= 1'b0;
            is_read_reg    <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                state_reg      <= state_next;
                phase_reg      <= phase_next;
                bit_reg        <= bit_next;
                shift_reg      <= shift_next;
                left_reg       <= left_next;
                dev_reg        <= dev_next;
                regaddr_reg    <= regaddr_next;
                pend_reg       <= pend_next;
                pend_valid_reg <= pend_valid_next;
                ack_reg        <= ack_next;
                is_read_reg    <= is_read_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

/* rtl/core/i2c_master_register_transfer.sv */
// I2C master for register writes and reads, driven one bus phase per tick word.
// Every accepted input word yields exactly one result word, and a new word can
// be accepted every clock cycle while the two-entry queue is not full: words
// pass through that queue into a sequencer that handles one word per cycle
// while the output register is free or drains, and each result sits in that
// output register, after the queue entry. Begin words (write or read) are
// ignored while a transaction runs; data words refill the single pending write
// byte, and the sequencer holds SCL low with need_data set until one arrives.
// A missing ACK ends the transaction with a stop and success low.
module i2c_master_register_transfer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  i2cm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output i2cm_pkg::out_t m_data
);

    i2cm_pkg::cmd_t       front_cmd;
    i2cm_pkg::cmd_t       head_cmd;
    i2cm_pkg::fifo_stat_t fifo_stat;
    logic                 pop;

    assign s_ready = !fifo_stat.full;

    // decode incoming words
    i2cm_front u_front (
        .in_word (s_data),
        .cmd     (front_cmd)
    );

    // queue between decode and sequencer
    i2cm_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid && s_ready),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (fifo_stat)
    );

    // bus sequencer and result register
    i2cm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (head_cmd),
        .stat    (fifo_stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // a finished transaction leaves the engine idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done reported while still busy");

    // success only accompanies a stop
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.success |-> m_data.done_res)
        else $error("success without done");

    // a received byte only appears mid transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_valid |-> m_data.busy_res && !m_data.need_data)
        else $error("read byte outside a read");

    // a data stall only happens inside a running write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.need_data |-> m_data.busy_res && !m_data.done_res)
        else $error("data stall outside a transfer");
`endif

endmodule
